// ===== rtl/core/sct_pkg.sv =====
// sct_pkg: shared types and constants for the sprite corner transform core
// used by every module under rtl/core, depends on nothing

package sct_pkg;

    // 16.16 fixed point one
    localparam logic [31:0] FIX_ONE = 32'h0001_0000;

    // one full turn in 16.16 degrees, 360 * 65536 = 45 << 19
    localparam logic [24:0] TURN_FIX  = 25'd23592960;
    localparam int          ANG_SHIFT = 19;
    localparam int          ANG_DIV   = 45;
    localparam logic [26:0] ANG_RECIP = 27'((64'd1 << 32) / ANG_DIV);

    // sine table entries, signed, magnitude up to 65536
    localparam int SINE_W = 18;

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_SCALED    = 2'd1,
        MODE_DISTORTED = 2'd2
    } draw_mode_t;

    typedef enum logic [0:0] {
        REG_SCROLL_X = 1'b0,
        REG_SCROLL_Y = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [30:0] width;
        logic [30:0] height;
        logic [31:0] scale;
        logic [24:0] angle;
        logic [1:0]  mirror;
        logic [6:0]  tile;
    } sprite_in_t;

    typedef struct packed {
        draw_mode_t               mode;
        logic [31:0]              x;
        logic [31:0]              y;
        logic [31:0]              sum_x;
        logic [31:0]              sum_y;
        logic [31:0]              half_x;
        logic [31:0]              half_y;
        logic signed [SINE_W-1:0] sn;
        logic signed [SINE_W-1:0] cs;
        logic [6:0]               tile;
        logic [1:0]               mirror;
    } sprite_t;

    typedef struct packed {
        draw_mode_t               mode;
        logic [1:0]               corner;
        logic                     last;
        logic [31:0]              base_x;
        logic [31:0]              base_y;
        logic [31:0]              off_x;
        logic [31:0]              off_y;
        logic signed [SINE_W-1:0] sn;
        logic signed [SINE_W-1:0] cs;
        logic [6:0]               tile;
        logic [1:0]               mirror;
    } corner_t;

    typedef struct packed {
        logic [15:0] vertex_x;
        logic [15:0] vertex_y;
        logic [1:0]  corner;
        draw_mode_t  mode;
        logic [6:0]  tile;
        logic [1:0]  mirror;
        logic        last;
    } result_t;

endpackage

// ===== rtl/core/sct_sprite_front.sv =====
// sct_sprite_front: six-stage per-sprite pipeline, scroll, mode, scaling,
// angle to table index and registered sine/cosine table read
// depends on sct_pkg

module sct_sprite_front #(
    parameter int SINE_ENTRIES = 1024,
    parameter int TILE_COUNT   = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sct_pkg::sprite_in_t in_data,
    input  logic [31:0]         scroll_x,
    input  logic [31:0]         scroll_y,
    output logic                spr_valid,
    input  logic                spr_ready,
    output sct_pkg::sprite_t    spr
);

    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam int IDXP_W  = IDX_W + 1;
    localparam int P_W     = 26 + IDX_W;
    localparam int Q_W     = P_W - sct_pkg::ANG_SHIFT;
    localparam int M_W     = Q_W + 27;
    localparam int SW      = sct_pkg::SINE_W;
    localparam int QUARTER = SINE_ENTRIES / 4;

    typedef logic signed [SW-1:0] sine_rom_t [SINE_ENTRIES];
    typedef logic [6:0] tile_tab_t [128];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        logic [63:0]       ang;
        logic [63:0]       sq;
        logic [63:0]       term;
        logic [63:0]       mag;
        logic signed [63:0] acc;
        logic              neg;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            ang = (64'(k) * sct_pkg::TWO_PI_Q30) / SINE_ENTRIES;
            neg = 1'b0;
            if (ang >= sct_pkg::PI_Q30) begin
                ang = ang - sct_pkg::PI_Q30;
                neg = 1'b1;
            end
            if (ang > sct_pkg::HALF_PI_Q30) begin
                ang = (sct_pkg::PI_Q30 > ang) ? sct_pkg::PI_Q30 - ang : 64'd0;
            end
            sq   = (ang * ang) >> 30;
            term = ang;
            acc  = $signed(ang);
            term = ((term * sq) >> 30) / 64'd6;
            acc  = acc - $signed(term);
            term = ((term * sq) >> 30) / 64'd20;
            acc  = acc + $signed(term);
            term = ((term * sq) >> 30) / 64'd42;
            acc  = acc - $signed(term);
            term = ((term * sq) >> 30) / 64'd72;
            acc  = acc + $signed(term);
            term = ((term * sq) >> 30) / 64'd110;
            acc  = acc - $signed(term);
            term = ((term * sq) >> 30) / 64'd156;
            acc  = acc + $signed(term);
            term = ((term * sq) >> 30) / 64'd210;
            acc  = acc - $signed(term);
            if (acc < 0) begin
                acc = 64'sd0;
            end
            mag    = ($unsigned(acc) + 64'd8192) >> 14;
            rom[k] = neg ? -SW'(mag) : SW'(mag);
        end
        return rom;
    endfunction

    function automatic tile_tab_t build_tile_tab();
        tile_tab_t tab;
        for (int t = 0; t < 128; t++) begin
            tab[t] = 7'(t % TILE_COUNT);
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam tile_tab_t TILE_TAB = build_tile_tab();

    typedef struct packed {
        sct_pkg::draw_mode_t mode;
        logic [31:0]         x;
        logic [31:0]         y;
        logic [6:0]          tile;
        logic [1:0]          mirror;
    } base_t;

    typedef struct packed {
        logic [31:0] sum_x;
        logic [31:0] sum_y;
        logic [31:0] half_x;
        logic [31:0] half_y;
    } geo_t;

    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic [5:0] rdy;

    // stage 1
    base_t       s1_base_reg;
    logic [30:0] s1_w_reg;
    logic [30:0] s1_h_reg;
    logic [31:0] s1_scale_reg;
    logic [24:0] s1_ang_reg;
    sct_pkg::draw_mode_t mode_c;
    logic [24:0] ang_norm;

    // stage 2
    base_t          s2_base_reg;
    logic [31:0]    s2_mx_reg;
    logic [31:0]    s2_my_reg;
    logic [Q_W-1:0] s2_q_reg;
    logic [31:0]    mul_w;
    logic [31:0]    mul_h;
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_y;
    logic [P_W-1:0] ang_prod;

    // stage 3
    base_t            s3_base_reg;
    geo_t             s3_geo_reg;
    logic [IDX_W-1:0] s3_e_reg;
    logic [Q_W-1:0]   s3_q_reg;
    logic [M_W-1:0]   e_prod;

    // stage 4
    base_t            s4_base_reg;
    geo_t             s4_geo_reg;
    logic [IDX_W-1:0] s4_e_reg;
    logic [6:0]       s4_r_reg;
    logic [Q_W-1:0]   r_full;

    // stage 5
    base_t            s5_base_reg;
    geo_t             s5_geo_reg;
    logic [IDX_W-1:0] s5_idx_reg;
    logic [IDX_W-1:0] s5_cidx_reg;
    logic [IDX_W-1:0] idx_c;
    logic [IDXP_W-1:0] csum;
    logic [IDX_W-1:0] cidx_c;

    // stage 6
    sct_pkg::sprite_t s6_reg;

    always_comb begin
        rdy[5] = !vld_reg[5] || spr_ready;
        for (int i = 4; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < 6; i++) begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready  = rdy[0];
    assign spr_valid = vld_reg[5];
    assign spr       = s6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: scroll, mode, angle folded into one turn, tile wrap
    always_comb begin
        ang_norm = in_data.angle[24] ? 25'(in_data.angle + sct_pkg::TURN_FIX)
                                     : in_data.angle;
        if (in_data.angle == '0 && in_data.scale == sct_pkg::FIX_ONE) begin
            mode_c = sct_pkg::MODE_NORMAL;
        end else if (in_data.angle == '0) begin
            mode_c = sct_pkg::MODE_SCALED;
        end else begin
            mode_c = sct_pkg::MODE_DISTORTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_base_reg.mode   <= mode_c;
            s1_base_reg.x      <= in_data.x_pos - scroll_x;
            s1_base_reg.y      <= in_data.y_pos - scroll_y;
            s1_base_reg.tile   <= TILE_TAB[in_data.tile];
            s1_base_reg.mirror <= in_data.mirror;
            s1_w_reg           <= in_data.width;
            s1_h_reg           <= in_data.height;
            s1_scale_reg       <= in_data.scale;
            s1_ang_reg         <= ang_norm;
        end
    end

    // stage 2: size times scale, angle times table size
    always_comb begin
        if (s1_base_reg.mode == sct_pkg::MODE_SCALED) begin
            mul_w = {1'b0, s1_w_reg};
            mul_h = {1'b0, s1_h_reg};
        end else begin
            mul_w = {2'b00, s1_w_reg[30:1]};
            mul_h = {2'b00, s1_h_reg[30:1]};
        end
        prod_x   = $signed(mul_w) * $signed(s1_scale_reg);
        prod_y   = $signed(mul_h) * $signed(s1_scale_reg);
        ang_prod = P_W'(s1_ang_reg) * P_W'(SINE_ENTRIES);
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s2_base_reg <= s1_base_reg;
            s2_mx_reg   <= prod_x[47:16];
            s2_my_reg   <= prod_y[47:16];
            s2_q_reg    <= ang_prod[P_W-1:sct_pkg::ANG_SHIFT];
        end
    end

    // stage 3: quotient estimate by reciprocal, corner or centre sums
    assign e_prod = M_W'(s2_q_reg) * M_W'(sct_pkg::ANG_RECIP);

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s3_base_reg       <= s2_base_reg;
            s3_geo_reg.sum_x  <= s2_base_reg.x + s2_mx_reg;
            s3_geo_reg.sum_y  <= s2_base_reg.y + s2_my_reg;
            s3_geo_reg.half_x <= s2_mx_reg;
            s3_geo_reg.half_y <= s2_my_reg;
            s3_e_reg          <= e_prod[32 +: IDX_W];
            s3_q_reg          <= s2_q_reg;
        end
    end

    // stage 4: remainder of the estimate
    assign r_full = s3_q_reg - Q_W'(s3_e_reg) * Q_W'(sct_pkg::ANG_DIV);

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            s4_base_reg <= s3_base_reg;
            s4_geo_reg  <= s3_geo_reg;
            s4_e_reg    <= s3_e_reg;
            s4_r_reg    <= r_full[6:0];
        end
    end

    // stage 5: corrected sine index and quarter-turn cosine index
    always_comb begin
        idx_c  = s4_e_reg + IDX_W'(s4_r_reg >= 7'(sct_pkg::ANG_DIV));
        csum   = {1'b0, idx_c} + IDXP_W'(QUARTER);
        cidx_c = (csum >= IDXP_W'(SINE_ENTRIES)) ? IDX_W'(csum - IDXP_W'(SINE_ENTRIES))
                                                : csum[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            s5_base_reg <= s4_base_reg;
            s5_geo_reg  <= s4_geo_reg;
            s5_idx_reg  <= idx_c;
            s5_cidx_reg <= cidx_c;
        end
    end

    // stage 6: table read
    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            s6_reg.mode   <= s5_base_reg.mode;
            s6_reg.x      <= s5_base_reg.x;
            s6_reg.y      <= s5_base_reg.y;
            s6_reg.sum_x  <= s5_geo_reg.sum_x;
            s6_reg.sum_y  <= s5_geo_reg.sum_y;
            s6_reg.half_x <= s5_geo_reg.half_x;
            s6_reg.half_y <= s5_geo_reg.half_y;
            s6_reg.sn     <= SINE_ROM[s5_idx_reg];
            s6_reg.cs     <= SINE_ROM[s5_cidx_reg];
            s6_reg.tile   <= s5_base_reg.tile;
            s6_reg.mirror <= s5_base_reg.mirror;
        end
    end

endmodule

// ===== rtl/core/sct_corner_expand.sv =====
// sct_corner_expand: turns one sprite into one, two or four corner transfers,
// one per cycle while crn_ready allows, with signed corner offsets
// depends on sct_pkg

module sct_corner_expand (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             spr_valid,
    output logic             spr_ready,
    input  sct_pkg::sprite_t spr,
    output logic             crn_valid,
    input  logic             crn_ready,
    output sct_pkg::corner_t crn
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             crn_valid_reg;
    logic             crn_valid_next;
    sct_pkg::corner_t crn_reg;
    sct_pkg::corner_t crn_next;
    logic [1:0]       final_cnt;
    logic             load;
    logic             emit;
    logic             is_last;

    always_comb begin
        unique case (spr.mode)
            sct_pkg::MODE_NORMAL:    final_cnt = sct_pkg::CORNER_TL;
            sct_pkg::MODE_SCALED:    final_cnt = sct_pkg::CORNER_TR;
            sct_pkg::MODE_DISTORTED: final_cnt = sct_pkg::CORNER_BL;
            default:                 final_cnt = sct_pkg::CORNER_BL;
        endcase
    end

    assign load      = !crn_valid_reg || crn_ready;
    assign emit      = spr_valid && load;
    assign is_last   = cnt_reg == final_cnt;
    assign spr_ready = !spr_valid || (load && is_last);
    assign crn_valid = crn_valid_reg;
    assign crn       = crn_reg;

    always_comb begin
        cnt_next       = cnt_reg;
        crn_valid_next = crn_valid_reg;
        if (load) begin
            crn_valid_next = spr_valid;
        end
        if (emit) begin
            cnt_next = is_last ? sct_pkg::CORNER_TL : 2'(cnt_reg + 2'd1);
        end

        crn_next.mode   = spr.mode;
        crn_next.corner = cnt_reg;
        crn_next.last   = is_last;
        crn_next.sn     = spr.sn;
        crn_next.cs     = spr.cs;
        crn_next.tile   = spr.tile;
        crn_next.mirror = spr.mirror;
        if (spr.mode == sct_pkg::MODE_DISTORTED || cnt_reg != sct_pkg::CORNER_TL) begin
            crn_next.base_x = spr.sum_x;
            crn_next.base_y = spr.sum_y;
        end else begin
            crn_next.base_x = spr.x;
            crn_next.base_y = spr.y;
        end
        if (cnt_reg == sct_pkg::CORNER_TL || cnt_reg == sct_pkg::CORNER_BL) begin
            crn_next.off_x = 32'd0 - spr.half_x;
        end else begin
            crn_next.off_x = spr.half_x;
        end
        if (cnt_reg == sct_pkg::CORNER_TL || cnt_reg == sct_pkg::CORNER_TR) begin
            crn_next.off_y = 32'd0 - spr.half_y;
        end else begin
            crn_next.off_y = spr.half_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= sct_pkg::CORNER_TL;
            crn_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            crn_valid_reg <= crn_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            crn_reg <= crn_next;
        end
    end

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        spr_valid |-> cnt_reg <= final_cnt)
        else $error("corner count beyond the last corner of the sprite mode");

    a_sprite_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !is_last) |=> (spr_valid && cnt_reg == 2'($past(cnt_reg) + 2'd1)))
        else $error("sprite dropped or count skipped in the middle of its corners");

    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != sct_pkg::CORNER_TL |-> spr_valid)
        else $error("corner count running without a sprite");

endmodule

// ===== rtl/core/sct_corner_math.sv =====
// sct_corner_math: rotation products per corner and the output register
// depends on sct_pkg

module sct_corner_math (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             crn_valid,
    output logic             crn_ready,
    input  sct_pkg::corner_t crn,
    output logic             res_valid,
    input  logic             res_ready,
    output sct_pkg::result_t res
);

    localparam int PR_W = 32 + sct_pkg::SINE_W;

    logic p_vld_reg;
    logic p_vld_next;
    logic o_vld_reg;
    logic o_vld_next;
    logic rdy_p;
    logic rdy_o;

    logic signed [PR_W-1:0] xc;
    logic signed [PR_W-1:0] ys;
    logic signed [PR_W-1:0] xs;
    logic signed [PR_W-1:0] yc;

    logic [31:0]         pa_reg;
    logic [31:0]         pb_reg;
    logic [31:0]         pc_reg;
    logic [31:0]         pd_reg;
    logic [31:0]         p_base_x_reg;
    logic [31:0]         p_base_y_reg;
    sct_pkg::draw_mode_t p_mode_reg;
    logic [1:0]          p_corner_reg;
    logic                p_last_reg;
    logic [6:0]          p_tile_reg;
    logic [1:0]          p_mirror_reg;

    logic [31:0]      vx;
    logic [31:0]      vy;
    sct_pkg::result_t res_reg;

    assign rdy_o      = !o_vld_reg || res_ready;
    assign rdy_p      = !p_vld_reg || rdy_o;
    assign crn_ready  = rdy_p;
    assign p_vld_next = rdy_p ? crn_valid : p_vld_reg;
    assign o_vld_next = rdy_o ? p_vld_reg : o_vld_reg;
    assign res_valid  = o_vld_reg;
    assign res        = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= p_vld_next;
            o_vld_reg <= o_vld_next;
        end
    end

    // offsets times sine and cosine, 16.16
    always_comb begin
        xc = $signed(crn.off_x) * crn.cs;
        ys = $signed(crn.off_y) * crn.sn;
        xs = $signed(crn.off_x) * crn.sn;
        yc = $signed(crn.off_y) * crn.cs;
    end

    always_ff @(posedge aclk) begin
        if (rdy_p) begin
            pa_reg       <= xc[47:16];
            pb_reg       <= ys[47:16];
            pc_reg       <= xs[47:16];
            pd_reg       <= yc[47:16];
            p_base_x_reg <= crn.base_x;
            p_base_y_reg <= crn.base_y;
            p_mode_reg   <= crn.mode;
            p_corner_reg <= crn.corner;
            p_last_reg   <= crn.last;
            p_tile_reg   <= crn.tile;
            p_mirror_reg <= crn.mirror;
        end
    end

    always_comb begin
        if (p_mode_reg == sct_pkg::MODE_DISTORTED) begin
            vx = pa_reg - pb_reg + p_base_x_reg;
            vy = pc_reg + pd_reg + p_base_y_reg;
        end else begin
            vx = p_base_x_reg;
            vy = p_base_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_o) begin
            res_reg.vertex_x <= vx[31:16];
            res_reg.vertex_y <= vy[31:16];
            res_reg.corner   <= p_corner_reg;
            res_reg.mode     <= p_mode_reg;
            res_reg.tile     <= p_tile_reg;
            res_reg.mirror   <= p_mirror_reg;
            res_reg.last     <= p_last_reg;
        end
    end

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (o_vld_reg && res_reg.last) |->
            ((res_reg.mode == sct_pkg::MODE_NORMAL && res_reg.corner == sct_pkg::CORNER_TL)
          || (res_reg.mode == sct_pkg::MODE_SCALED && res_reg.corner == sct_pkg::CORNER_TR)
          || (res_reg.mode == sct_pkg::MODE_DISTORTED
              && res_reg.corner == sct_pkg::CORNER_BL)))
        else $error("final corner does not match the draw mode");

endmodule

// ===== rtl/core/sprite_corner_transform_core.sv =====
// sprite_corner_transform_core: top level, scroll registers on the
// configuration port, stream unpacking and the three pipeline parts
// depends on sct_pkg, sct_sprite_front, sct_corner_expand, sct_corner_math
//
// One sprite enters per s_axis transfer: 16.16 position, size, scale and
// angle with tile and mirror flags. Each sprite leaves as corner transfers on
// m_axis: one (normal), two (scaled) or four (rotated), the final one with
// m_axis_tlast high. The scroll registers sit at byte addresses 0 and 4 and
// are written while no sprite is in flight: the user must keep to that, the block does not enforce it.
// The first corner passes the front stages, the corner, product and output
// registers; further corners follow one per cycle while m_axis_tready is high.
// Normal sprites are taken one per cycle while nothing stalls; a scaled or rotated
// sprite waits while the corner expander issues its two or four corners.
// The sine/cosine table is a constant table read in the sixth stage.
// Reset clears the scroll registers and all valid bits; the table needs no
// fill. When m_axis_tready is low the output register holds its corner and
// the stages behind it keep filling until each holds an item, then
// s_axis_tready falls; nothing is dropped or repeated.

module sprite_corner_transform_core #(
    parameter int SINE_ENTRIES = 1024,
    parameter int TILE_COUNT   = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // sprite input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // x_pos[31:0], y_pos[63:32], width[94:64], height[125:95], scale[157:126],
    // angle[182:158], mirror[184:183], tile[191:185]
    input  logic [191:0] s_axis_tdata,
    // corner output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_x[15:0], vertex_y[31:16], tile_out[38:32], mirror_out[40:39], zero[47:41]
    output logic [47:0]  m_axis_tdata,
    // corner[1:0], draw_mode[3:2]
    output logic [3:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    logic [31:0] scroll_x_reg;
    logic [31:0] scroll_y_reg;
    logic        cfg_write;

    sct_pkg::sprite_in_t in_data;
    sct_pkg::sprite_t    spr;
    logic                spr_valid;
    logic                spr_ready;
    sct_pkg::corner_t    crn;
    logic                crn_valid;
    logic                crn_ready;
    sct_pkg::result_t    res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_x_reg <= '0;
            scroll_y_reg <= '0;
        end else if (cfg_write) begin
            unique case (sct_pkg::cfg_reg_t'(paddr[2]))
                sct_pkg::REG_SCROLL_X: scroll_x_reg <= pwdata;
                sct_pkg::REG_SCROLL_Y: scroll_y_reg <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (sct_pkg::cfg_reg_t'(paddr[2]))
            sct_pkg::REG_SCROLL_X: prdata = scroll_x_reg;
            sct_pkg::REG_SCROLL_Y: prdata = scroll_y_reg;
        endcase
    end

    always_comb begin
        in_data.x_pos  = s_axis_tdata[31:0];
        in_data.y_pos  = s_axis_tdata[63:32];
        in_data.width  = s_axis_tdata[94:64];
        in_data.height = s_axis_tdata[125:95];
        in_data.scale  = s_axis_tdata[157:126];
        in_data.angle  = s_axis_tdata[182:158];
        in_data.mirror = s_axis_tdata[184:183];
        in_data.tile   = s_axis_tdata[191:185];
    end

    sct_sprite_front #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .TILE_COUNT   (TILE_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_data),
        .scroll_x  (scroll_x_reg),
        .scroll_y  (scroll_y_reg),
        .spr_valid (spr_valid),
        .spr_ready (spr_ready),
        .spr       (spr)
    );

    sct_corner_expand u_expand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .spr_valid (spr_valid),
        .spr_ready (spr_ready),
        .spr       (spr),
        .crn_valid (crn_valid),
        .crn_ready (crn_ready),
        .crn       (crn)
    );

    sct_corner_math u_math (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .crn_valid (crn_valid),
        .crn_ready (crn_ready),
        .crn       (crn),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {7'd0, res.mirror, res.tile, res.vertex_y, res.vertex_x};
    assign m_axis_tuser = {res.mode, res.corner};
    assign m_axis_tlast = res.last;

endmodule

// ===== dv/sct_checker.sv =====
`timescale 1ns / 1ps
// sct_checker: watches the apb port and both stream ports of the sprite corner
// transform core, predicts the corners of every sprite and compares them
// depends on sct_pkg

module sct_checker #(
    parameter int SINE_ENTRIES = 1024,
    parameter int TILE_COUNT   = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // x_pos, y_pos, width, height, scale, angle, mirror, tile
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_x, vertex_y, tile_out, mirror_out, zero
    input  logic [47:0]  m_axis_tdata,
    // corner, draw_mode
    input  logic [3:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           errors,
    output int           pending
);

    localparam int TURN = sct_pkg::TURN_FIX;

    int               sin_lut [SINE_ENTRIES];
    logic [31:0]      x_scroll;
    logic [31:0]      y_scroll;
    sct_pkg::result_t expected_corners [$];

    // sine of x in q30, x from 0 to a quarter turn
    function automatic longint unsigned sin_series(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint unsigned div;
        longint          sum;
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            div = (2 * n) * (2 * n + 1);
            t   = ((t * x2) >> 30) / div;
            if (n % 2 == 1) sum = sum - $signed(t);
            else sum = sum + $signed(t);
        end
        if (sum < 0) sum = 0;
        return sum;
    endfunction

    function automatic void fill_sin_lut();
        longint unsigned ang;
        longint unsigned mag;
        bit              neg;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            ang = (64'(k) * sct_pkg::TWO_PI_Q30) / 64'(SINE_ENTRIES);
            neg = 1'b0;
            if (ang >= sct_pkg::PI_Q30) begin
                ang = ang - sct_pkg::PI_Q30;
                neg = 1'b1;
            end
            if (ang > sct_pkg::HALF_PI_Q30) ang = sct_pkg::PI_Q30 - ang;
            mag = (sin_series(ang) + 8192) >> 14;
            sin_lut[k] = neg ? -int'(mag) : int'(mag);
        end
    endfunction

    // 16.16 product, wraps at 32 bits
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return p[47:16];
    endfunction

    function automatic void push_corner(input logic [31:0] vx, input logic [31:0] vy,
                                        input logic [1:0] corner,
                                        input sct_pkg::draw_mode_t mode,
                                        input logic [6:0] tile, input logic [1:0] mirror,
                                        input logic last);
        sct_pkg::result_t r;
        r.vertex_x = vx[31:16];
        r.vertex_y = vy[31:16];
        r.corner   = corner;
        r.mode     = mode;
        r.tile     = tile;
        r.mirror   = mirror;
        r.last     = last;
        expected_corners.push_back(r);
    endfunction

    function automatic void predict_corners(input sct_pkg::sprite_in_t sp);
        logic [31:0] px, py, w, h, hx, hy, xo, yo, cx, cy, sn, cs, vx, vy;
        logic [6:0]  tl;
        logic [1:0]  c;
        int          a;
        int          idx;
        px = sp.x_pos - x_scroll;
        py = sp.y_pos - y_scroll;
        w  = {1'b0, sp.width};
        h  = {1'b0, sp.height};
        tl = 7'(sp.tile % TILE_COUNT);
        if (sp.angle == '0 && sp.scale == sct_pkg::FIX_ONE) begin
            push_corner(px, py, sct_pkg::CORNER_TL, sct_pkg::MODE_NORMAL, tl, sp.mirror,
                        1'b1);
        end else if (sp.angle == '0) begin
            push_corner(px, py, sct_pkg::CORNER_TL, sct_pkg::MODE_SCALED, tl, sp.mirror,
                        1'b0);
            push_corner(fmul(w, sp.scale) + px, fmul(h, sp.scale) + py, sct_pkg::CORNER_TR,
                        sct_pkg::MODE_SCALED, tl, sp.mirror, 1'b1);
        end else begin
            a = $signed(sp.angle);
            if (a < 0) a = a + TURN;
            if (a >= TURN) a = a - TURN;
            idx = int'((longint'(a) * SINE_ENTRIES) / TURN) % SINE_ENTRIES;
            sn  = sin_lut[idx];
            cs  = sin_lut[(idx + SINE_ENTRIES / 4) % SINE_ENTRIES];
            hx  = fmul(w >> 1, sp.scale);
            hy  = fmul(h >> 1, sp.scale);
            xo  = -hx;
            yo  = -hy;
            cx  = px + hx;
            cy  = py + hy;
            for (int i = 0; i < 4; i++) begin
                c = 2'(i);
                if (c == sct_pkg::CORNER_TR || c == sct_pkg::CORNER_BL) xo = -xo;
                if (c == sct_pkg::CORNER_BR) yo = -yo;
                vx = fmul(xo, cs) - fmul(yo, sn) + cx;
                vy = fmul(xo, sn) + fmul(yo, cs) + cy;
                push_corner(vx, vy, c, sct_pkg::MODE_DISTORTED, tl, sp.mirror,
                            c == sct_pkg::CORNER_BL);
            end
        end
    endfunction

    function automatic string show(input sct_pkg::result_t r);
        return $sformatf("x=%0d y=%0d corner=%0d mode=%0d tile=%0d mirror=%0d last=%0d",
                         $signed(r.vertex_x), $signed(r.vertex_y), r.corner, r.mode,
                         r.tile, r.mirror, r.last);
    endfunction

    initial begin
        fill_sin_lut();
    end

    always @(posedge aclk) begin
        sct_pkg::sprite_in_t sp;
        sct_pkg::result_t    got;
        sct_pkg::result_t    want;
        if (!aresetn) begin
            x_scroll = '0;
            y_scroll = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (sct_pkg::cfg_reg_t'(paddr[2]))
                    sct_pkg::REG_SCROLL_X: x_scroll = pwdata;
                    sct_pkg::REG_SCROLL_Y: y_scroll = pwdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sp.x_pos  = s_axis_tdata[31:0];
                sp.y_pos  = s_axis_tdata[63:32];
                sp.width  = s_axis_tdata[94:64];
                sp.height = s_axis_tdata[125:95];
                sp.scale  = s_axis_tdata[157:126];
                sp.angle  = s_axis_tdata[182:158];
                sp.mirror = s_axis_tdata[184:183];
                sp.tile   = s_axis_tdata[191:185];
                predict_corners(sp);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.vertex_x = m_axis_tdata[15:0];
                got.vertex_y = m_axis_tdata[31:16];
                got.tile     = m_axis_tdata[38:32];
                got.mirror   = m_axis_tdata[40:39];
                got.corner   = m_axis_tuser[1:0];
                got.mode     = sct_pkg::draw_mode_t'(m_axis_tuser[3:2]);
                got.last     = m_axis_tlast;
                if (expected_corners.size() == 0) begin
                    errors++;
                    $display("%0t: corner mismatch, expected nothing, got %s", $time,
                             show(got));
                end else begin
                    want = expected_corners.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: corner mismatch, expected %s, got %s", $time,
                                 show(want), show(got));
                    end
                end
            end
        end
        pending = expected_corners.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: drives sprites and scroll writes into sprite_corner_transform_core
// with random idling on both sides and gives the verdict
// depends on sct_pkg, sct_checker and the core

module tb_top;

    localparam int SINE_ENTRIES = 1024;
    localparam int TILE_COUNT   = 128;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int BATCH        = 50;
    localparam int PHASES       = 6;
    localparam int FLUSH_CYCLES = 12;

    localparam logic [31:0] FIX_ONE = sct_pkg::FIX_ONE;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [2:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;
    int           errors;
    int           pending;
    int           idle_cycles   = 0;
    bit           tx_gaps       = 1'b0;
    bit           rx_free       = 1'b0;
    bit           hold_req      = 1'b0;

    always #4 aclk = ~aclk;

    sprite_corner_transform_core #(
        .SINE_ENTRIES(SINE_ENTRIES),
        .TILE_COUNT  (TILE_COUNT)
    ) i_dut (.*);

    sct_checker #(
        .SINE_ENTRIES(SINE_ENTRIES),
        .TILE_COUNT  (TILE_COUNT)
    ) i_checker (.*);

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // corner receiver
    initial begin
        int r;
        @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_free || r < 55) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end else if (r < 92) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge aclk);
            end
        end
    end

    task automatic apb_write(input sct_pkg::cfg_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_sprite(input sct_pkg::sprite_in_t sp);
        int r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sp.tile, sp.mirror, sp.angle, sp.scale, sp.height, sp.width,
                          sp.y_pos, sp.x_pos};
        do @(posedge aclk); while (!s_axis_tready);
        r   = $urandom_range(0, 99);
        gap = !tx_gaps ? 0 : r < 60 ? 0 : r < 92 ? $urandom_range(1, 3) :
              $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    function automatic sct_pkg::sprite_in_t mk_sprite(input logic [31:0] x,
                                                      input logic [31:0] y,
                                                      input logic [30:0] w,
                                                      input logic [30:0] h,
                                                      input logic [31:0] scale,
                                                      input logic [24:0] angle,
                                                      input logic [1:0] mirror,
                                                      input logic [6:0] tile);
        sct_pkg::sprite_in_t sp;
        sp.x_pos  = x;
        sp.y_pos  = y;
        sp.width  = w;
        sp.height = h;
        sp.scale  = scale;
        sp.angle  = angle;
        sp.mirror = mirror;
        sp.tile   = tile;
        return sp;
    endfunction

    function automatic sct_pkg::sprite_in_t rand_sprite();
        sct_pkg::sprite_in_t sp;
        int                  kind;
        bit                  wide;
        kind      = $urandom_range(0, 19);
        wide      = ($urandom_range(0, 4) == 0);
        sp.x_pos  = wide ? $urandom() : {16'($urandom_range(0, 400)), 16'($urandom())};
        sp.y_pos  = wide ? $urandom() : {16'($urandom_range(0, 300)), 16'($urandom())};
        sp.width  = wide ? 31'($urandom()) : {7'd0, 8'($urandom()), 16'($urandom())};
        sp.height = wide ? 31'($urandom()) : {7'd0, 8'($urandom()), 16'($urandom())};
        sp.scale  = wide ? $urandom() : 32'($urandom_range(8192, 327680));
        sp.angle  = 25'($urandom_range(0, 2 * 11796480) - 11796480);
        if (!wide && $urandom_range(0, 7) == 0) sp.scale = -sp.scale;
        if (wide && $urandom_range(0, 1) == 1) sp.angle = 25'($urandom());
        if (kind < 4) begin
            sp.scale = FIX_ONE;
            sp.angle = '0;
        end else if (kind < 9) begin
            sp.angle = '0;
        end
        sp.mirror = 2'($urandom());
        sp.tile   = 7'($urandom());
        return sp;
    endfunction

    initial begin
        logic [31:0] sx;
        logic [31:0] sy;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // normal sprites at the position, size, tile and mirror extremes
        push_sprite(mk_sprite('0, '0, '0, '0, FIX_ONE, '0, 2'd0, 7'd0));
        push_sprite(mk_sprite(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, '0, FIX_ONE, '0,
                              2'd1, 7'd127));
        push_sprite(mk_sprite(32'h8000_0000, 32'h7fff_ffff, '0, 31'h7fff_ffff, FIX_ONE, '0,
                              2'd2, 7'd85));
        push_sprite(mk_sprite(32'hffff_ffff, 32'h0001_8000, 31'h0010_0000, 31'h0010_0000,
                              FIX_ONE, '0, 2'd3, 7'd42));
        // scaled: ordinary, zero, negative, largest, most negative, smallest
        push_sprite(mk_sprite(32'h0020_0000, 32'h0030_0000, 31'h0010_0000, 31'h0008_0000,
                              32'h0002_0000, '0, 2'd0, 7'd1));
        push_sprite(mk_sprite(32'h0020_0000, 32'h0030_0000, 31'h0010_0000, 31'h0008_0000,
                              32'h0000_0000, '0, 2'd1, 7'd2));
        push_sprite(mk_sprite(32'h0020_0000, 32'h0030_0000, 31'h0010_0000, 31'h0008_0000,
                              32'hffff_0000, '0, 2'd2, 7'd3));
        push_sprite(mk_sprite(32'h0100_0000, 32'hff00_0000, 31'h7fff_ffff, 31'h0004_0000,
                              32'h7fff_ffff, '0, 2'd3, 7'd4));
        push_sprite(mk_sprite(32'hff00_0000, 32'h0100_0000, 31'h0004_0000, 31'h7fff_ffff,
                              32'h8000_0000, '0, 2'd0, 7'd5));
        push_sprite(mk_sprite(32'h0001_0000, 32'h0001_0000, 31'h7fff_ffff, 31'h7fff_ffff,
                              32'h0000_0001, '0, 2'd1, 7'd6));
        // rotated: quarter and half turns, smallest steps, angles past half a turn
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              FIX_ONE, 25'd5898240, 2'd0, 7'd10));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              FIX_ONE, 25'(-5898240), 2'd1, 7'd11));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              32'h0001_8000, 25'd11796480, 2'd2, 7'd12));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              32'h0000_8000, 25'(-11796480), 2'd3, 7'd13));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              FIX_ONE, 25'd1, 2'd0, 7'd14));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              FIX_ONE, 25'h1ff_ffff, 2'd1, 7'd15));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0030_0000, 31'h0030_0000,
                              32'h0002_0000, 25'd2949120, 2'd2, 7'd16));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              FIX_ONE, 25'h0ff_ffff, 2'd3, 7'd17));
        push_sprite(mk_sprite(32'h0040_0000, 32'h0040_0000, 31'h0020_0000, 31'h0010_0000,
                              FIX_ONE, 25'h100_0000, 2'd0, 7'd18));
        push_sprite(mk_sprite(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                              32'h8000_0000, 25'd1966080, 2'd3, 7'd127));
        push_sprite(mk_sprite(32'h0010_0000, 32'h0010_0000, 31'h7fff_ffff, 31'h7fff_ffff,
                              32'h7fff_ffff, 25'(-1966080), 2'd2, 7'd64));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    sx = 32'h7fff_ffff;
                    sy = 32'h8000_0000;
                end
                1: begin
                    sx = 32'h8000_0000;
                    sy = 32'h7fff_ffff;
                end
                5: begin
                    sx = '0;
                    sy = '0;
                end
                default: begin
                    sx = $urandom();
                    sy = $urandom();
                end
            endcase
            apb_write(sct_pkg::REG_SCROLL_X, sx);
            apb_write(sct_pkg::REG_SCROLL_Y, sy);
            tx_gaps = (ph % 2 == 1);
            rx_free = (ph == 4);
            // long receiver hold-off while sprites keep coming
            if (ph == 2) hold_req = 1'b1;
            repeat (BATCH) push_sprite(rand_sprite());
        end

        wait_drained();
        repeat (FLUSH_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sct_pkg.sv
rtl/core/sct_sprite_front.sv
rtl/core/sct_corner_expand.sv
rtl/core/sct_corner_math.sv
rtl/core/sprite_corner_transform_core.sv
dv/sct_checker.sv
dv/tb_top.sv
